### design/low_power_antenna_mode_decider_core_macros.svh
// Assertion macros used by the antenna mode decider checker.
`ifndef LOW_POWER_ANTENNA_MODE_DECIDER_CORE_MACROS_SVH
`define LOW_POWER_ANTENNA_MODE_DECIDER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LPAMD_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpamd: check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LPAMD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpamd: check failed");

`endif

### design/lpamd_pkg.sv
// Types and constants of the antenna mode decider.
`timescale 1ns / 1ps

package lpamd_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [2:0] {
    CMD_SAMPLE  = 3'd0,
    CMD_REPORT  = 3'd1,
    CMD_ENABLE  = 3'd2,
    CMD_DISABLE = 3'd3,
    CMD_CLOSE   = 3'd4
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NEWER_CHIP  = 3'd0,
    REG_LEGACY_MAX  = 3'd1,
    REG_HT_ONLY     = 3'd2,
    REG_HT_11G      = 3'd3,
    REG_HT_ONLY_2G  = 3'd4,
    REG_LOW_RATE    = 3'd5,
    REG_HIGH_RATE   = 3'd6,
    REG_HOLD_MS     = 3'd7
  } cfg_reg_e;

  localparam logic [1:0] MODE_NONE     = 2'd0;
  localparam logic [1:0] MODE_SISO     = 2'd1;
  localparam logic [1:0] MODE_MIMO_OLD = 2'd2;
  localparam logic [1:0] MODE_MIMO_NEW = 2'd3;

  localparam logic [3:0] CNT_MIN = 4'd3;
  localparam logic [3:0] CNT_MID = 4'd6;
  localparam logic [3:0] CNT_MAX = 4'd9;

  typedef struct packed {
    logic        newer_chip;
    logic [3:0]  legacy_protocol_max;
    logic [3:0]  ht_only_code;
    logic [3:0]  ht_11g_code;
    logic [3:0]  ht_only_2g_code;
    logic [9:0]  low_rate_mbps;
    logic [9:0]  high_rate_mbps;
    logic [31:0] hold_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    newer_chip:          1'b1,
    legacy_protocol_max: 4'd5,
    ht_only_code:        4'd7,
    ht_11g_code:         4'd9,
    ht_only_2g_code:     4'd11,
    low_rate_mbps:       10'd10,
    high_rate_mbps:      10'd60,
    hold_ms:             32'd60000
  };

  typedef struct packed {
    logic        feature_enabled;
    logic        bt_forbidden;
    logic        device_allowed;
    logic        single_chain_on;
    logic [3:0]  rate_counter;
    logic [31:0] last_switch_ms;
  } state_t;

  localparam state_t STATE_RESET = '{
    feature_enabled: 1'b0,
    bt_forbidden:    1'b0,
    device_allowed:  1'b0,
    single_chain_on: 1'b0,
    rate_counter:    CNT_MID,
    last_switch_ms:  32'd0
  };

  typedef struct packed {
    logic [2:0]  command;
    logic        eligible;
    logic [3:0]  protocol_code;
    logic [15:0] tx_mbps;
    logic [15:0] rx_mbps;
    logic [31:0] now_ms;
    logic        abort_request;
    logic        device_permits;
    logic        bt_lock;
  } in_word_t;

  typedef struct packed {
    logic       switch_issued;
    logic       to_single_chain;
    logic [1:0] mode_code;
    logic       switch_state;
    logic       enabled_now;
  } out_word_t;

endpackage

### design/lpamd_if.sv
// Valid/ready channels for input and result words.
`timescale 1ns / 1ps

interface lpamd_in_if;
  logic                 valid;
  logic                 ready;
  lpamd_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lpamd_out_if;
  logic                  valid;
  logic                  ready;
  lpamd_pkg::out_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/lpamd_decide.sv
// Next-state and result logic for one event word.
`timescale 1ns / 1ps

module lpamd_decide (
  input  lpamd_pkg::cfg_t      cfg_i,
  input  lpamd_pkg::state_t    st_i,
  input  lpamd_pkg::in_word_t  word_i,
  output lpamd_pkg::state_t    st_o,
  output lpamd_pkg::out_word_t res_o
);

  logic [16:0] total;
  logic        cnt_up;
  logic        cnt_down;
  logic [3:0]  cnt_inc;
  logic [3:0]  cnt_new;
  logic        proto_ok;
  logic        wish;
  logic [31:0] hold_end;
  logic [31:0] hold_left;
  logic        held;
  logic        issued;
  logic        target;

  assign total    = {1'b0, word_i.tx_mbps} + {1'b0, word_i.rx_mbps};
  assign cnt_up   = total < {7'd0, cfg_i.low_rate_mbps};
  assign cnt_down = total > {7'd0, cfg_i.high_rate_mbps};

  // counter lives in 3..9; up then down when both limits are crossed
  assign cnt_inc = !cnt_up ? st_i.rate_counter :
                   (st_i.rate_counter >= lpamd_pkg::CNT_MAX) ? lpamd_pkg::CNT_MAX :
                   st_i.rate_counter + 4'd1;
  assign cnt_new = !cnt_down ? cnt_inc :
                   (cnt_inc <= lpamd_pkg::CNT_MIN) ? lpamd_pkg::CNT_MIN :
                   cnt_inc - 4'd1;

  assign proto_ok = !((word_i.protocol_code <= cfg_i.legacy_protocol_max) ||
                      (word_i.protocol_code == cfg_i.ht_only_code) ||
                      (word_i.protocol_code == cfg_i.ht_11g_code) ||
                      (word_i.protocol_code == cfg_i.ht_only_2g_code));
  assign wish = (cnt_new >= lpamd_pkg::CNT_MID) && proto_ok && st_i.device_allowed;

  // hold over once the wrapped distance to the deadline goes negative
  assign hold_end  = st_i.last_switch_ms + cfg_i.hold_ms;
  assign hold_left = hold_end - word_i.now_ms;
  assign held      = hold_left[31];

  always_comb begin
    st_o   = st_i;
    issued = 1'b0;
    target = 1'b0;
    case (word_i.command)
      lpamd_pkg::CMD_SAMPLE: begin
        if (st_i.feature_enabled && !st_i.bt_forbidden && word_i.eligible) begin
          st_o.rate_counter = cnt_new;
          if ((st_i.single_chain_on != wish) && (!wish || held)) begin
            st_o.last_switch_ms  = word_i.now_ms;
            st_o.single_chain_on = wish;
            issued               = 1'b1;
            target               = wish;
          end
        end
      end
      lpamd_pkg::CMD_REPORT: begin
        st_o.single_chain_on = !word_i.bt_lock &&
                               (st_i.single_chain_on ^ word_i.abort_request);
        st_o.device_allowed  = word_i.device_permits;
        st_o.bt_forbidden    = word_i.bt_lock;
      end
      lpamd_pkg::CMD_ENABLE: begin
        if (word_i.eligible && !st_i.feature_enabled) begin
          st_o.device_allowed  = 1'b0;
          st_o.single_chain_on = 1'b0;
          st_o.rate_counter    = lpamd_pkg::CNT_MID;
          st_o.last_switch_ms  = '0;
          st_o.feature_enabled = 1'b1;
        end
      end
      lpamd_pkg::CMD_DISABLE: begin
        if (word_i.eligible && st_i.feature_enabled) begin
          st_o.device_allowed  = 1'b0;
          st_o.single_chain_on = 1'b0;
          st_o.rate_counter    = lpamd_pkg::CNT_MID;
          st_o.last_switch_ms  = '0;
          st_o.feature_enabled = 1'b0;
          issued               = !st_i.bt_forbidden;
        end
      end
      lpamd_pkg::CMD_CLOSE: begin
        if (st_i.feature_enabled) begin
          st_o.feature_enabled = 1'b0;
          if (!st_i.bt_forbidden) begin
            st_o.single_chain_on = 1'b0;
            issued               = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_o.switch_issued   = issued;
    res_o.to_single_chain = issued && target;
    if (!issued) begin
      res_o.mode_code = lpamd_pkg::MODE_NONE;
    end else if (target) begin
      res_o.mode_code = lpamd_pkg::MODE_SISO;
    end else if (cfg_i.newer_chip) begin
      res_o.mode_code = lpamd_pkg::MODE_MIMO_NEW;
    end else begin
      res_o.mode_code = lpamd_pkg::MODE_MIMO_OLD;
    end
    res_o.switch_state = st_o.single_chain_on;
    res_o.enabled_now  = st_o.feature_enabled;
  end

endmodule

### design/low_power_antenna_mode_decider_core.sv
// Top level of the low-power antenna mode decider.
// Takes one event word per cycle while the result side is not stalled and returns exactly one
// result word for each: the word is captured in an input
// register, the decision and state update run in one pass of compare-and-count logic, and the
// result lands in an output register. The decision state updates as a word leaves the input
// register, so consecutive words always see the effect of the one before. Configuration
// registers are written through cfg_we/cfg_idx/cfg_wdata and must only change while idle.
`timescale 1ns / 1ps

module low_power_antenna_mode_decider_core (
  input  logic                                clk,
  input  logic                                rst_n,
  lpamd_in_if.sink                            in_ch,
  lpamd_out_if.source                         out_ch,
  input  logic                                cfg_we,
  input  logic [lpamd_pkg::CfgIdxW-1:0]       cfg_idx,
  input  logic [lpamd_pkg::CfgDataW-1:0]      cfg_wdata
);

  lpamd_pkg::cfg_t      cfg_r;
  lpamd_pkg::state_t    state_r;
  lpamd_pkg::state_t    state_nxt;
  lpamd_pkg::in_word_t  in_word_r;
  logic                 in_valid_r;
  lpamd_pkg::out_word_t out_word_r;
  lpamd_pkg::out_word_t out_word_nxt;
  logic                 out_valid_r;
  logic                 out_free;
  logic                 advance;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign advance     = in_valid_r && out_free;
  assign in_ch.ready = !in_valid_r || out_free;

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  lpamd_decide u_decide (
    .cfg_i  (cfg_r),
    .st_i   (state_r),
    .word_i (in_word_r),
    .st_o   (state_nxt),
    .res_o  (out_word_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= lpamd_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (lpamd_pkg::cfg_reg_e'(cfg_idx))
        lpamd_pkg::REG_NEWER_CHIP: cfg_r.newer_chip          <= cfg_wdata[0];
        lpamd_pkg::REG_LEGACY_MAX: cfg_r.legacy_protocol_max <= cfg_wdata[3:0];
        lpamd_pkg::REG_HT_ONLY:    cfg_r.ht_only_code        <= cfg_wdata[3:0];
        lpamd_pkg::REG_HT_11G:     cfg_r.ht_11g_code         <= cfg_wdata[3:0];
        lpamd_pkg::REG_HT_ONLY_2G: cfg_r.ht_only_2g_code     <= cfg_wdata[3:0];
        lpamd_pkg::REG_LOW_RATE:   cfg_r.low_rate_mbps       <= cfg_wdata[9:0];
        lpamd_pkg::REG_HIGH_RATE:  cfg_r.high_rate_mbps      <= cfg_wdata[9:0];
        lpamd_pkg::REG_HOLD_MS:    cfg_r.hold_ms             <= cfg_wdata[31:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= lpamd_pkg::STATE_RESET;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_word_r <= in_ch.data;
    end
    if (advance) begin
      out_word_r <= out_word_nxt;
    end
  end

endmodule

### design/lpamd_checker.sv
// Port-level checks on the decider's result words, bound to the top level.
`timescale 1ns / 1ps
`include "low_power_antenna_mode_decider_core_macros.svh"

module lpamd_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input lpamd_pkg::out_word_t out_data
);

  // no switch: target and mode code stay zero
  `LPAMD_ASSERT_IMPLY(a_no_switch_quiet, out_valid && !out_data.switch_issued, !out_data.to_single_chain && (out_data.mode_code == lpamd_pkg::MODE_NONE))

  // a single chain switch leaves the feature on and the flag set
  `LPAMD_ASSERT_IMPLY(a_siso_switch, out_valid && out_data.switch_issued && out_data.to_single_chain, (out_data.mode_code == lpamd_pkg::MODE_SISO) && out_data.switch_state && out_data.enabled_now)

  // a MIMO switch clears the flag and uses one of the MIMO codes
  `LPAMD_ASSERT_IMPLY(a_mimo_switch, out_valid && out_data.switch_issued && !out_data.to_single_chain, !out_data.switch_state && ((out_data.mode_code == lpamd_pkg::MODE_MIMO_OLD) || (out_data.mode_code == lpamd_pkg::MODE_MIMO_NEW)))

  // a stalled word is held
  `LPAMD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind low_power_antenna_mode_decider_core lpamd_checker u_lpamd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
